/* hw/rtl/lswc_pkg.sv */
// Shared types, constants and outcode helper for the line segment window clipper.
// No dependencies.
package lswc_pkg;

    localparam int CW = 16;         // coordinate width
    localparam int DW = CW + 1;     // coordinate difference width
    localparam int PW = 2 * CW;     // product / dividend width
    localparam int MAX_STEPS = 8;   // boundary moves before giving up

    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    localparam logic [2:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [2:0] REG_WIN_BOTTOM = 3'd1;
    localparam logic [2:0] REG_WIN_RIGHT  = 3'd2;
    localparam logic [2:0] REG_WIN_TOP    = 3'd3;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } t_seg;

    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] clip_start_x;
        logic signed [CW-1:0] clip_start_y;
        logic signed [CW-1:0] clip_end_x;
        logic signed [CW-1:0] clip_end_y;
    } t_result;

    typedef struct packed {
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] bottom;
        logic signed [CW-1:0] right;
        logic signed [CW-1:0] top;
    } t_win;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_pt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div_step;
        logic update;
        logic emit;
        logic vis;
    } t_cmd;

    typedef struct packed {
        logic triv_accept;
        logic triv_reject;
    } t_status;

    function automatic logic [3:0] outcode(input t_pt p, input t_win w);
        logic [3:0] c;
        c = 4'd0;
        if (p.y > w.top)    c = c | OC_TOP;
        if (p.y < w.bottom) c = c | OC_BOTTOM;
        if (p.x > w.right)  c = c | OC_RIGHT;
        if (p.x < w.left)   c = c | OC_LEFT;
        return c;
    endfunction

endpackage

/* hw/rtl/lswc_datapath.sv */
// Datapath of the clipper: window registers, endpoints, multiplier and serial divider.
// Depends on lswc_pkg.
module lswc_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [lswc_pkg::CW-1:0] i_cfg_data,
    input  lswc_pkg::t_seg       i_seg,
    input  lswc_pkg::t_cmd       i_cmd,
    output lswc_pkg::t_status    o_status,
    output lswc_pkg::t_result    o_result
);

    localparam int CW = lswc_pkg::CW;
    localparam int DW = lswc_pkg::DW;
    localparam int PW = lswc_pkg::PW;

    lswc_pkg::t_win    r_win;
    lswc_pkg::t_pt     r_pt [2];
    lswc_pkg::t_result r_result;

    logic                 r_e;
    logic                 r_vert;
    logic                 r_neg;
    logic                 r_den_zero;
    logic signed [CW-1:0] r_bound;
    logic signed [CW-1:0] r_base;
    logic [CW-1:0]        r_a;
    logic [CW-1:0]        r_b;
    logic [CW-1:0]        r_c;
    logic [PW-1:0]        r_q;
    logic [CW-1:0]        r_rem;

    logic [3:0]           c0, c1, c_sel;
    logic                 e_sel;
    lswc_pkg::t_pt        p_e, p_o;
    logic signed [CW-1:0] bound_sel;
    logic signed [DW-1:0] d_s, num_s, den_s;
    logic [DW-1:0]        d_m, num_m, den_m;
    logic [DW-1:0]        rem_sh;
    logic                 fits;
    logic signed [DW:0]   res_s;
    logic signed [DW:0]   new_s;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    always_comb begin
        c0    = lswc_pkg::outcode(r_pt[0], r_win);
        c1    = lswc_pkg::outcode(r_pt[1], r_win);
        o_status.triv_accept = ((c0 | c1) == 4'd0);
        o_status.triv_reject = ((c0 & c1) != 4'd0);
        e_sel = (c0 == 4'd0);
        c_sel = e_sel ? c1 : c0;
        p_e   = r_pt[e_sel];
        p_o   = r_pt[!e_sel];
        if ((c_sel & (lswc_pkg::OC_TOP | lswc_pkg::OC_BOTTOM)) != 4'd0) begin
            bound_sel = ((c_sel & lswc_pkg::OC_TOP) != 4'd0) ? r_win.top : r_win.bottom;
            d_s   = DW'(p_o.x) - DW'(p_e.x);
            num_s = DW'(bound_sel) - DW'(p_e.y);
            den_s = DW'(p_o.y) - DW'(p_e.y);
        end else begin
            bound_sel = ((c_sel & lswc_pkg::OC_RIGHT) != 4'd0) ? r_win.right : r_win.left;
            d_s   = DW'(p_o.y) - DW'(p_e.y);
            num_s = DW'(bound_sel) - DW'(p_e.x);
            den_s = DW'(p_o.x) - DW'(p_e.x);
        end
        d_m   = mag(d_s);
        num_m = mag(num_s);
        den_m = mag(den_s);
    end

    // Restoring division step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh = {r_rem, r_q[PW-1]};
        fits   = (rem_sh >= {1'b0, r_c});
        res_s  = r_neg ? -(DW+1)'({1'b0, r_q[CW-1:0]}) : (DW+1)'({1'b0, r_q[CW-1:0]});
        if (r_den_zero) res_s = '0;
        new_s  = (DW+1)'(r_base) + res_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= CW'(0);
            r_win.bottom <= CW'(0);
            r_win.right  <= CW'(639);
            r_win.top    <= CW'(479);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lswc_pkg::REG_WIN_LEFT:   r_win.left   <= i_cfg_data;
                lswc_pkg::REG_WIN_BOTTOM: r_win.bottom <= i_cfg_data;
                lswc_pkg::REG_WIN_RIGHT:  r_win.right  <= i_cfg_data;
                lswc_pkg::REG_WIN_TOP:    r_win.top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pt[0] <= '{x: i_seg.start_x, y: i_seg.start_y};
            r_pt[1] <= '{x: i_seg.end_x,   y: i_seg.end_y};
        end else if (i_cmd.update) begin
            if (r_vert) begin
                r_pt[r_e].x <= new_s[CW-1:0];
                r_pt[r_e].y <= r_bound;
            end else begin
                r_pt[r_e].y <= new_s[CW-1:0];
                r_pt[r_e].x <= r_bound;
            end
        end
        if (i_cmd.setup) begin
            r_e        <= e_sel;
            r_vert     <= ((c_sel & (lswc_pkg::OC_TOP | lswc_pkg::OC_BOTTOM)) != 4'd0);
            r_bound    <= bound_sel;
            r_base     <= ((c_sel & (lswc_pkg::OC_TOP | lswc_pkg::OC_BOTTOM)) != 4'd0)
                          ? p_e.x : p_e.y;
            r_neg      <= d_s[DW-1] ^ num_s[DW-1] ^ den_s[DW-1];
            r_den_zero <= (den_m == '0);
            r_a        <= d_m[CW-1:0];
            r_b        <= num_m[CW-1:0];
            r_c        <= den_m[CW-1:0];
        end
        if (i_cmd.mul) begin
            r_q   <= r_a * r_b;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_q   <= {r_q[PW-2:0], fits};
            r_rem <= fits ? CW'(rem_sh - {1'b0, r_c}) : rem_sh[CW-1:0];
        end
        if (i_cmd.emit) begin
            r_result.visible      <= i_cmd.vis;
            r_result.clip_start_x <= i_cmd.vis ? r_pt[0].x : '0;
            r_result.clip_start_y <= i_cmd.vis ? r_pt[0].y : '0;
            r_result.clip_end_x   <= i_cmd.vis ? r_pt[1].x : '0;
            r_result.clip_end_y   <= i_cmd.vis ? r_pt[1].y : '0;
        end
    end

    assign o_result = r_result;

endmodule

/* hw/rtl/lswc_ctrl.sv */
// Controller state machine of the clipper: sequences setup, multiply, divide and update.
// Depends on lswc_pkg.
module lswc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lswc_pkg::t_status  i_status,
    output lswc_pkg::t_cmd     o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    localparam int PW = lswc_pkg::PW;

    lswc_pkg::t_state          r_state, n_state;
    logic [$clog2(PW)-1:0]     r_cnt, n_cnt;
    logic [3:0]                r_step, n_step;
    logic                      r_vis, n_vis;
    logic                      r_strobe;
    logic                      give_up;

    assign give_up = i_status.triv_reject || (r_step >= 4'(lswc_pkg::MAX_STEPS));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_vis   = r_vis;
        case (r_state)
            lswc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = lswc_pkg::ST_EVAL;
                    n_step  = '0;
                end
            end
            lswc_pkg::ST_EVAL: begin
                if (i_status.triv_accept) begin
                    n_vis   = 1'b1;
                    n_state = lswc_pkg::ST_DONE;
                end else if (give_up) begin
                    n_vis   = 1'b0;
                    n_state = lswc_pkg::ST_DONE;
                end else begin
                    n_state = lswc_pkg::ST_MUL;
                end
            end
            lswc_pkg::ST_MUL: begin
                n_cnt   = '0;
                n_state = lswc_pkg::ST_DIV;
            end
            lswc_pkg::ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ($clog2(PW))'(PW - 1)) n_state = lswc_pkg::ST_UPDATE;
            end
            lswc_pkg::ST_UPDATE: begin
                n_step  = r_step + 1'b1;
                n_state = lswc_pkg::ST_EVAL;
            end
            lswc_pkg::ST_DONE: n_state = lswc_pkg::ST_IDLE;
            default:           n_state = lswc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            lswc_pkg::ST_IDLE:   o_cmd.load     = i_start;
            lswc_pkg::ST_EVAL:   o_cmd.setup    = 1'b1;
            lswc_pkg::ST_MUL:    o_cmd.mul      = 1'b1;
            lswc_pkg::ST_DIV:    o_cmd.div_step = 1'b1;
            lswc_pkg::ST_UPDATE: o_cmd.update   = 1'b1;
            lswc_pkg::ST_DONE: begin
                o_cmd.emit = 1'b1;
                o_cmd.vis  = r_vis;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lswc_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_step   <= '0;
            r_vis    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_vis    <= n_vis;
            r_strobe <= (r_state == lswc_pkg::ST_DONE);
        end
    end

    assign o_busy = (r_state != lswc_pkg::ST_IDLE);
    assign o_done = r_strobe;

    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state == lswc_pkg::ST_DONE))
        else $error("result strobe without a finished transaction");

    a_step_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lswc_pkg::ST_EVAL) |-> (r_step <= 4'(lswc_pkg::MAX_STEPS)))
        else $error("clip step count overran its limit");

    a_update_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lswc_pkg::ST_UPDATE) |-> ($past(r_state == lswc_pkg::ST_DIV)
        && $past(r_cnt) == ($clog2(PW))'(PW - 1)))
        else $error("endpoint update before the division finished");

endmodule

/* hw/rtl/line_segment_window_clipper_unit.sv */
// Top level of the Cohen-Sutherland line segment window clipper.
// Depends on lswc_pkg, lswc_ctrl and lswc_datapath.
//
// Usage: pulse i_start with a segment on i_seg while o_busy is low; the
// transaction is taken at that edge. The clipped segment appears on o_result,
// marked by o_done, which is high for exactly one cycle; the receiver cannot stall it, so
// capture it then. A segment that is trivially accepted or rejected passes
// through load, evaluation and done; each boundary move adds setup, one 16x16
// multiply, the shared bit-serial divider and one update, with at most 8 moves
// and usually no more than 4. The serial divider dominates the time per move.
// A new segment may start in the cycle
// o_done is shown. Window registers are written through the configuration
// channel, which is always ready; write it only while o_busy is low.
// Indexes beyond the four window registers are dropped.
module line_segment_window_clipper_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  lswc_pkg::t_seg          i_seg,
    output logic                    o_done,
    output lswc_pkg::t_result       o_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [lswc_pkg::CW-1:0] i_cfg_data
);

    lswc_pkg::t_cmd    cmd;
    lswc_pkg::t_status status;
    logic              start_acc;

    // Accept a transaction only when idle.
    assign start_acc   = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;

    lswc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start_acc),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    lswc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_seg       (i_seg),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (o_result)
    );

endmodule

/* verif/line_segment_window_clipper_unit_tb.sv */
// Self-checking testbench for the line segment window clipper.
// Depends on lswc_pkg and line_segment_window_clipper_unit; predicts each
// clipped segment in the testbench and compares it with o_result on o_done.
module line_segment_window_clipper_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_start;
    logic                        o_busy;
    lswc_pkg::t_seg              i_seg;
    logic                        o_done;
    lswc_pkg::t_result           o_result;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [2:0]                  i_cfg_index;
    logic [lswc_pkg::CW-1:0]     i_cfg_data;

    line_segment_window_clipper_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_seg       (i_seg),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Window as the testbench believes it to be programmed.
    lswc_pkg::t_win    win_shadow;
    lswc_pkg::t_seg    pending_segs[$];
    lswc_pkg::t_result clipped_expected[$];
    int                idle_pct;
    int                fail_count;
    int                seg_sent;
    int                seg_checked;
    int                visible_seen;
    int                idle_cycles;
    bit                driver_en;
    bit                seg_taken;

    // trunc(d * num / den); the product fits easily in 64 bits.
    function automatic longint scale_trunc(longint d, longint num, longint den);
        longint p;
        p = d * num;
        if (den == 0) return 0;
        return p / den;  // SystemVerilog division truncates toward zero
    endfunction

    function automatic logic [3:0] region_code(longint x, longint y, lswc_pkg::t_win w);
        logic [3:0] c;
        c = 4'd0;
        if (y > longint'(w.top))    c = c | lswc_pkg::OC_TOP;
        if (y < longint'(w.bottom)) c = c | lswc_pkg::OC_BOTTOM;
        if (x > longint'(w.right))  c = c | lswc_pkg::OC_RIGHT;
        if (x < longint'(w.left))   c = c | lswc_pkg::OC_LEFT;
        return c;
    endfunction

    function automatic lswc_pkg::t_result clip_segment(lswc_pkg::t_seg s, lswc_pkg::t_win w);
        longint            px[2];
        longint            py[2];
        logic [3:0]        c0, c1, c;
        int                e, o;
        bit                vis;
        longint            bound;
        lswc_pkg::t_result r;
        px[0] = s.start_x; py[0] = s.start_y;
        px[1] = s.end_x;   py[1] = s.end_y;
        vis = 1'b0;
        for (int step = 0; ; step++) begin
            c0 = region_code(px[0], py[0], w);
            c1 = region_code(px[1], py[1], w);
            if ((c0 | c1) == 4'd0) begin
                vis = 1'b1;
                break;
            end
            if ((c0 & c1) != 4'd0 || step >= lswc_pkg::MAX_STEPS) break;
            e = (c0 != 4'd0) ? 0 : 1;
            o = 1 - e;
            c = (e == 0) ? c0 : c1;
            if ((c & (lswc_pkg::OC_TOP | lswc_pkg::OC_BOTTOM)) != 4'd0) begin
                bound = ((c & lswc_pkg::OC_TOP) != 4'd0) ? longint'(w.top)
                                                         : longint'(w.bottom);
                px[e] = px[e] + scale_trunc(px[o] - px[e], bound - py[e], py[o] - py[e]);
                py[e] = bound;
            end else begin
                bound = ((c & lswc_pkg::OC_RIGHT) != 4'd0) ? longint'(w.right)
                                                           : longint'(w.left);
                py[e] = py[e] + scale_trunc(py[o] - py[e], bound - px[e], px[o] - px[e]);
                px[e] = bound;
            end
        end
        r = '0;
        if (vis) begin
            r.visible      = 1'b1;
            r.clip_start_x = px[0][lswc_pkg::CW-1:0];
            r.clip_start_y = py[0][lswc_pkg::CW-1:0];
            r.clip_end_x   = px[1][lswc_pkg::CW-1:0];
            r.clip_end_y   = py[1][lswc_pkg::CW-1:0];
        end
        return r;
    endfunction

    // Driver: present segments at the falling edge, with random idle gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n || !driver_en) begin
            i_start <= 1'b0;
        end else if (i_start && !seg_taken) begin
            // hold the current transaction until the block takes it
        end else if (pending_segs.size() != 0 &&
                     $urandom_range(99) >= idle_pct) begin
            i_seg   <= pending_segs.pop_front();
            i_start <= 1'b1;
        end else begin
            i_start <= 1'b0;
        end
    end

    // Monitor: take transactions and results at the rising edge.
    always @(posedge i_clk) begin
        lswc_pkg::t_result want;
        seg_taken <= i_rst_n && i_start && !o_busy;
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_start && !o_busy) begin
                clipped_expected.push_back(clip_segment(i_seg, win_shadow));
                seg_sent <= seg_sent + 1;
            end
            if (o_done) begin
                if (clipped_expected.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_result);
                    fail_count++;
                end else begin
                    want = clipped_expected.pop_front();
                    seg_checked <= seg_checked + 1;
                    if (want.visible) visible_seen <= visible_seen + 1;
                    if (o_result.visible !== want.visible ||
                        o_result.clip_start_x !== want.clip_start_x ||
                        o_result.clip_start_y !== want.clip_start_y ||
                        o_result.clip_end_x !== want.clip_end_x ||
                        o_result.clip_end_y !== want.clip_end_y) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, want, o_result);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: stop if nothing is accepted and no result arrives for too long.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_window(logic [2:0] idx, logic signed [lswc_pkg::CW-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            lswc_pkg::REG_WIN_LEFT:   win_shadow.left   = val;
            lswc_pkg::REG_WIN_BOTTOM: win_shadow.bottom = val;
            lswc_pkg::REG_WIN_RIGHT:  win_shadow.right  = val;
            lswc_pkg::REG_WIN_TOP:    win_shadow.top    = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_window(int l, int b, int r, int t);
        write_window(lswc_pkg::REG_WIN_LEFT,   l[lswc_pkg::CW-1:0]);
        write_window(lswc_pkg::REG_WIN_BOTTOM, b[lswc_pkg::CW-1:0]);
        write_window(lswc_pkg::REG_WIN_RIGHT,  r[lswc_pkg::CW-1:0]);
        write_window(lswc_pkg::REG_WIN_TOP,    t[lswc_pkg::CW-1:0]);
    endtask

    // Drain: wait for every queued segment and result, then let the block settle.
    task automatic drain_results();
        while (pending_segs.size() != 0 || clipped_expected.size() != 0 ||
               i_start) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic lswc_pkg::t_seg make_seg(int sx, int sy, int ex, int ey);
        lswc_pkg::t_seg s;
        s.start_x = sx[lswc_pkg::CW-1:0];
        s.start_y = sy[lswc_pkg::CW-1:0];
        s.end_x   = ex[lswc_pkg::CW-1:0];
        s.end_y   = ey[lswc_pkg::CW-1:0];
        return s;
    endfunction

    // Mostly coordinates near the window, so segments cross its edges.
    function automatic int near_coord(int lo, int hi);
        int span;
        span = hi - lo;
        if (span < 0) span = -span;
        case ($urandom_range(9))
            0: return $urandom_range(65535) - 32768;
            1: return $urandom_range(1) ? lo : hi;
            default: return lo - span / 2 + int'($urandom_range(span * 2 + 4));
        endcase
    endfunction

    function automatic lswc_pkg::t_seg random_seg();
        int xl, xh, yl, yh;
        int sx, sy, ex, ey;
        xl = win_shadow.left; xh = win_shadow.right;
        yl = win_shadow.bottom; yh = win_shadow.top;
        sx = near_coord(xl, xh); sy = near_coord(yl, yh);
        ex = near_coord(xl, xh); ey = near_coord(yl, yh);
        case ($urandom_range(9))
            0: ex = sx;  // vertical
            1: ey = sy;  // horizontal
            default: ;
        endcase
        sx = (sx > 32767) ? 32767 : (sx < -32768) ? -32768 : sx;
        sy = (sy > 32767) ? 32767 : (sy < -32768) ? -32768 : sy;
        ex = (ex > 32767) ? 32767 : (ex < -32768) ? -32768 : ex;
        ey = (ey > 32767) ? 32767 : (ey < -32768) ? -32768 : ey;
        return make_seg(sx, sy, ex, ey);
    endfunction

    initial begin
        int phase_idle[4];
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_seg       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = lswc_pkg::REG_WIN_LEFT;
        i_cfg_data  = '0;
        driver_en   = 1'b0;
        seg_taken   = 1'b0;
        idle_pct    = 0;
        fail_count  = 0;
        seg_sent    = 0;
        seg_checked = 0;
        visible_seen = 0;
        idle_cycles = 0;
        win_shadow.left = 16'sd0;   win_shadow.bottom = 16'sd0;
        win_shadow.right = 16'sd639; win_shadow.top = 16'sd479;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        driver_en = 1'b1;

        // Directed: reset window first, then extremes, axes and corners.
        pending_segs.push_back(make_seg(10, 10, 600, 400));        // inside
        pending_segs.push_back(make_seg(-100, 700, -50, 900));     // both left/top
        pending_segs.push_back(make_seg(-100, 240, 800, 240));     // horizontal across
        pending_segs.push_back(make_seg(320, -500, 320, 900));     // vertical across
        pending_segs.push_back(make_seg(-32768, -32768, 32767, 32767));
        pending_segs.push_back(make_seg(32767, -32768, -32768, 32767));
        pending_segs.push_back(make_seg(-10, 470, 20, 500));       // corner graze
        pending_segs.push_back(make_seg(0, 0, 639, 479));          // on the edges
        pending_segs.push_back(make_seg(700, 0, 0, 700));          // near-miss cut
        pending_segs.push_back(make_seg(-32768, 0, -32768, 479));  // outside left
        pending_segs.push_back(make_seg(-1, -1, -1, -1));          // point outside
        pending_segs.push_back(make_seg(100, 100, 100, 100));      // point inside
        drain_results();

        // Extreme window covering the whole range.
        set_window(-32768, -32768, 32767, 32767);
        pending_segs.push_back(make_seg(-32768, 32767, 32767, -32768));
        pending_segs.push_back(make_seg(12345, -23456, -1, 0));
        drain_results();
        // Inverted window: every point is outside.
        set_window(100, 100, -100, -100);
        pending_segs.push_back(make_seg(-200, 0, 200, 0));
        pending_segs.push_back(make_seg(0, -200, 0, 200));
        pending_segs.push_back(make_seg(-300, -250, 250, 300));
        drain_results();
        // Single-point window and a window at the positive corner.
        set_window(5, 5, 5, 5);
        pending_segs.push_back(make_seg(0, 0, 10, 10));
        pending_segs.push_back(make_seg(0, 5, 10, 5));
        drain_results();
        set_window(32000, 32000, 32767, 32767);
        pending_segs.push_back(make_seg(-32768, -32768, 32767, 32767));
        pending_segs.push_back(make_seg(31000, 32767, 32767, 31000));
        drain_results();

        // Random phases: eight phases rotate through four window kinds, each with its idle level.
        phase_idle = '{0, 60, 6, 0};
        for (int ph = 0; ph < 8; ph++) begin
            int l, b, w, h;
            case (ph % 4)
                0: begin l = -320; b = -240; w = 640; h = 480; end
                1: begin l = $urandom_range(2000) - 1000; b = $urandom_range(2000) - 1000;
                         w = $urandom_range(3000); h = $urandom_range(3000); end
                2: begin l = -30000; b = -30000; w = 60000; h = 60000; end
                default: begin l = $urandom_range(200); b = $urandom_range(200);
                               w = $urandom_range(40) + 1; h = $urandom_range(40) + 1; end
            endcase
            set_window(l, b, l + w, b + h);
            idle_pct = phase_idle[ph % 4];
            for (int n = 0; n < 205; n++) pending_segs.push_back(random_seg());
            drain_results();
        end

        $display("Clipped %0d segments (%0d visible) over several windows and idle levels.",
                 seg_checked, visible_seen);
        if (fail_count == 0 && clipped_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
